[rtl/h263_rtp_depacketizer_rfc4629_assert.svh]
// Assertion macros shared by the depacketizer checker.
`ifndef H263_RTP_DEPACKETIZER_RFC4629_ASSERT_SVH
`define H263_RTP_DEPACKETIZER_RFC4629_ASSERT_SVH

// Clocked assertion that is switched off while reset is high.
`define H263DEP_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define H263DEP_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

[rtl/h263dep_pkg.sv]
// Types and constants shared by the H.263 RTP depacketizer modules.
package h263dep_pkg;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_INVALID = 2'd1,
      ST_SMALL   = 2'd2,
      ST_IGNORED = 2'd3
   } status_type;

   localparam logic OP_BYTE = 1'b0;
   localparam logic OP_LOST = 1'b1;

   // Payload header layout: P is 0x04 and V is 0x02 of the first byte, PLEN takes
   // bit 0 of the first byte and bits 0xF8 of the second byte.
   localparam int P_FLAG_BIT    = 2;
   localparam int V_FLAG_BIT    = 1;
   localparam int PLEN_HIGH_BIT = 0;
   localparam int PLEN_LOW_LSB  = 3;

   localparam logic [15:0] MIN_PACKET_LENGTH  = 16'd2;
   localparam logic [15:0] BYTE_INDEX_MAX     = 16'hFFFF;
   localparam logic [6:0]  BASE_HEADER_LENGTH = 7'd2;
   localparam logic [17:0] SYNC_ROOM          = 18'd2;
   localparam logic [15:0] BUFFER_SIZE_RESET  = 16'hFFFF;

   localparam logic [1:0] WRITES_NONE = 2'd0;
   localparam logic [1:0] WRITES_ONE  = 2'd1;
   localparam logic [1:0] WRITES_PAIR = 2'd2;

   localparam int QUEUE_DEPTH     = 4;
   localparam int REQ_TDATA_WIDTH = 32;
   localparam int RSP_TDATA_WIDTH = 48;
   localparam int REQ_PAD_WIDTH   = 7;
   localparam int RSP_PAD_WIDTH   = 6;

   typedef struct packed {
      logic        op;
      logic [7:0]  data_byte;
      logic        first_byte;
      logic        last_byte;
      logic [15:0] packet_length;
      logic        picture_start;
   } req_item_type;

   // One queued command: a group of writes and an optional closing status.
   typedef struct packed {
      logic [15:0] new_position;
      status_type  status;
      logic        status_valid;
      logic [7:0]  write_byte;
      logic [1:0]  write_count;
   } cmd_info_type;

   typedef struct packed {
      logic        write_valid;
      logic [15:0] write_addr;
      logic [7:0]  write_byte;
      logic        status_valid;
      status_type  status;
      logic [15:0] new_position;
      logic        last_result;
   } rsp_item_type;

endpackage

[rtl/h263dep_queue.sv]
// Small command queue between the parsing front end and the result stage.
module h263dep_queue #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic             full,
   output logic             head_valid,
   output logic [WIDTH-1:0] head_data
);

   localparam int DEPTH = h263dep_pkg::QUEUE_DEPTH;
   localparam int PTR_W = $clog2(DEPTH);

   logic [WIDTH-1:0] slots_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PTR_W:0]   count_ff, count_in;
   logic             do_push, do_pop;

   assign full       = (count_ff == (PTR_W + 1)'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_data  = slots_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + (PTR_W + 1)'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - (PTR_W + 1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

[rtl/h263dep_front.sv]
// Front end: payload header parsing, sync search, room check and write commands.
module h263dep_front #(
   parameter int ADDR_WIDTH = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       item_accept,
   input  h263dep_pkg::req_item_type  item,
   input  logic                       csr_write,
   input  logic [15:0]                csr_data,
   output logic                       cmd_push,
   output h263dep_pkg::cmd_info_type  cmd_info,
   output logic [ADDR_WIDTH-1:0]      cmd_addr
);

   logic                    in_packet_ff, in_packet_in;
   logic [15:0]             byte_index_ff, byte_index_in;
   logic [15:0]             write_position_ff, write_position_in;
   logic [ADDR_WIDTH-1:0]   sync_position_ff, sync_position_in;
   logic [ADDR_WIDTH-1:0]   output_pointer_ff, output_pointer_in;
   logic                    previous_lost_ff, previous_lost_in;
   logic                    sync_flag_ff, sync_flag_in;
   logic                    vrc_flag_ff, vrc_flag_in;
   logic [5:0]              header_extra_ff, header_extra_in;
   logic                    searching_ff, searching_in;
   logic                    prior_zero_ff, prior_zero_in;
   h263dep_pkg::status_type outcome_ff, outcome_in;
   logic [15:0]             buffer_size_ff, buffer_size_in;
   logic                    push_in;

   function automatic logic [15:0] ptr_to_16(input logic [ADDR_WIDTH-1:0] ptr);
      logic [ADDR_WIDTH+15:0] wide;
      wide = {16'd0, ptr};
      return wide[15:0];
   endfunction

   function automatic logic [ADDR_WIDTH-1:0] pos_to_ptr(input logic [15:0] pos);
      logic [ADDR_WIDTH+15:0] wide;
      wide = {{ADDR_WIDTH{1'b0}}, pos};
      return wide[ADDR_WIDTH-1:0];
   endfunction

   assign buffer_size_in = csr_write ? csr_data : buffer_size_ff;
   assign cmd_push       = item_accept && push_in;

   always_comb begin
      logic [6:0]  hdr;
      logic [6:0]  hdr_base;
      logic [17:0] need;
      logic [15:0] idx;
      logic [16:0] idx_plus;
      logic [15:0] len;
      logic [7:0]  b;

      in_packet_in      = in_packet_ff;
      byte_index_in     = byte_index_ff;
      write_position_in = write_position_ff;
      sync_position_in  = sync_position_ff;
      output_pointer_in = output_pointer_ff;
      previous_lost_in  = previous_lost_ff;
      sync_flag_in      = sync_flag_ff;
      vrc_flag_in       = vrc_flag_ff;
      header_extra_in   = header_extra_ff;
      searching_in      = searching_ff;
      prior_zero_in     = prior_zero_ff;
      outcome_in        = outcome_ff;

      push_in               = 1'b0;
      cmd_addr              = output_pointer_ff;
      cmd_info.new_position = '0;
      cmd_info.status       = h263dep_pkg::ST_OK;
      cmd_info.status_valid = 1'b0;
      cmd_info.write_byte   = '0;
      cmd_info.write_count  = h263dep_pkg::WRITES_NONE;

      hdr      = '0;
      hdr_base = '0;
      need     = '0;
      idx      = '0;
      idx_plus = '0;
      len      = item.packet_length;
      b        = item.data_byte;

      if (item.op == h263dep_pkg::OP_LOST) begin
         previous_lost_in      = 1'b1;
         push_in               = 1'b1;
         cmd_info.status_valid = 1'b1;
         cmd_info.status       = h263dep_pkg::ST_OK;
         cmd_info.new_position = write_position_ff;
      end else begin
         // A first byte abandons whatever packet was in flight.
         if (item.first_byte) begin
            in_packet_in    = 1'b1;
            byte_index_in   = '0;
            if (item.picture_start) begin
               write_position_in = '0;
            end
            outcome_in        = h263dep_pkg::ST_OK;
            searching_in      = 1'b0;
            prior_zero_in     = 1'b0;
            sync_flag_in      = 1'b0;
            vrc_flag_in       = 1'b0;
            header_extra_in   = '0;
            output_pointer_in = pos_to_ptr(write_position_in);
         end

         if (in_packet_in) begin
            idx      = byte_index_in;
            idx_plus = {1'b0, idx} + 17'd1;
            if (item.last_byte && outcome_in == h263dep_pkg::ST_OK &&
                idx_plus < {1'b0, len}) begin
               outcome_in = h263dep_pkg::ST_INVALID;
            end

            if (outcome_in == h263dep_pkg::ST_OK) begin
               hdr_base = h263dep_pkg::BASE_HEADER_LENGTH + {6'd0, vrc_flag_in};
               hdr      = hdr_base + {1'b0, header_extra_in};
               priority if (idx == 16'd0) begin
                  if (len < h263dep_pkg::MIN_PACKET_LENGTH) begin
                     outcome_in = h263dep_pkg::ST_INVALID;
                  end else begin
                     if (write_position_in == '0) begin
                        sync_position_in = '0;
                     end
                     sync_flag_in    = b[h263dep_pkg::P_FLAG_BIT];
                     vrc_flag_in     = b[h263dep_pkg::V_FLAG_BIT];
                     header_extra_in = {b[h263dep_pkg::PLEN_HIGH_BIT], 5'd0};
                  end
               end else if (idx == 16'd1) begin
                  header_extra_in = {header_extra_in[5], b[h263dep_pkg::PLEN_LOW_LSB +: 5]};
                  hdr = h263dep_pkg::BASE_HEADER_LENGTH + {6'd0, vrc_flag_in}
                        + {1'b0, header_extra_in};
                  if (len <= {9'd0, hdr}) begin
                     outcome_in = h263dep_pkg::ST_INVALID;
                  end else begin
                     need = {2'b0, write_position_in} + {2'b0, len - {9'd0, hdr}}
                            + h263dep_pkg::SYNC_ROOM;
                     // A new picture without the P flag also copies the extra header.
                     if (!sync_flag_in && write_position_in == '0) begin
                        need = need + {12'd0, header_extra_in};
                     end
                     if ({2'b0, buffer_size_ff} < need) begin
                        outcome_in = h263dep_pkg::ST_SMALL;
                     end else begin
                        prior_zero_in     = 1'b0;
                        searching_in      = 1'b0;
                        output_pointer_in = pos_to_ptr(write_position_in);
                        if (!sync_flag_in) begin
                           if (write_position_in == '0) begin
                              previous_lost_in = 1'b1;
                              if (header_extra_in != '0) begin
                                 cmd_addr             = output_pointer_in;
                                 cmd_info.write_count = h263dep_pkg::WRITES_PAIR;
                                 output_pointer_in    = output_pointer_in + ADDR_WIDTH'(2);
                              end
                           end else if (previous_lost_in) begin
                              output_pointer_in = sync_position_in;
                           end
                           searching_in = previous_lost_in;
                        end else begin
                           // The P flag stands for the two zero bytes of a start code.
                           sync_position_in     = output_pointer_in;
                           cmd_addr             = output_pointer_in;
                           cmd_info.write_count = h263dep_pkg::WRITES_PAIR;
                           output_pointer_in    = output_pointer_in + ADDR_WIDTH'(2);
                        end
                     end
                  end
               end else if (idx < {9'd0, hdr}) begin
                  // Extra picture header bytes are copied only on a fresh picture.
                  if (!sync_flag_in && write_position_in == '0 &&
                      idx >= {9'd0, hdr_base}) begin
                     cmd_addr             = output_pointer_in;
                     cmd_info.write_byte  = b;
                     cmd_info.write_count = h263dep_pkg::WRITES_ONE;
                     output_pointer_in    = output_pointer_in + ADDR_WIDTH'(1);
                  end
               end else if (idx < len) begin
                  if (searching_in) begin
                     if (prior_zero_in && b == 8'd0) begin
                        searching_in         = 1'b0;
                        prior_zero_in        = 1'b0;
                        sync_position_in     = output_pointer_in;
                        cmd_addr             = output_pointer_in;
                        cmd_info.write_count = h263dep_pkg::WRITES_PAIR;
                        output_pointer_in    = output_pointer_in + ADDR_WIDTH'(2);
                     end else begin
                        prior_zero_in = (b == 8'd0);
                     end
                  end else begin
                     cmd_addr             = output_pointer_in;
                     cmd_info.write_byte  = b;
                     cmd_info.write_count = h263dep_pkg::WRITES_ONE;
                     output_pointer_in    = output_pointer_in + ADDR_WIDTH'(1);
                  end
               end else begin
                  // Bytes past the declared length are dropped.
               end
            end

            if (idx != h263dep_pkg::BYTE_INDEX_MAX) begin
               byte_index_in = idx + 16'd1;
            end

            if (item.last_byte) begin
               cmd_info.status = outcome_in;
               if (outcome_in == h263dep_pkg::ST_OK) begin
                  if (searching_in) begin
                     cmd_info.status = h263dep_pkg::ST_IGNORED;
                  end else begin
                     write_position_in = ptr_to_16(output_pointer_in);
                     previous_lost_in  = 1'b0;
                  end
               end else begin
                  previous_lost_in = 1'b1;
               end
               cmd_info.status_valid = 1'b1;
               cmd_info.new_position = write_position_in;
               in_packet_in          = 1'b0;
            end

            push_in = cmd_info.status_valid ||
                      (cmd_info.write_count != h263dep_pkg::WRITES_NONE);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_packet_ff      <= 1'b0;
         byte_index_ff     <= '0;
         write_position_ff <= '0;
         sync_position_ff  <= '0;
         output_pointer_ff <= '0;
         previous_lost_ff  <= 1'b0;
         sync_flag_ff      <= 1'b0;
         vrc_flag_ff       <= 1'b0;
         header_extra_ff   <= '0;
         searching_ff      <= 1'b0;
         prior_zero_ff     <= 1'b0;
         outcome_ff        <= h263dep_pkg::ST_OK;
         buffer_size_ff    <= h263dep_pkg::BUFFER_SIZE_RESET;
      end else begin
         buffer_size_ff <= buffer_size_in;
         if (item_accept) begin
            in_packet_ff      <= in_packet_in;
            byte_index_ff     <= byte_index_in;
            write_position_ff <= write_position_in;
            sync_position_ff  <= sync_position_in;
            output_pointer_ff <= output_pointer_in;
            previous_lost_ff  <= previous_lost_in;
            sync_flag_ff      <= sync_flag_in;
            vrc_flag_ff       <= vrc_flag_in;
            header_extra_ff   <= header_extra_in;
            searching_ff      <= searching_in;
            prior_zero_ff     <= prior_zero_in;
            outcome_ff        <= outcome_in;
         end
      end
   end

endmodule

[rtl/h263dep_back.sv]
// Result stage: expands one queued command into write and status results.
module h263dep_back #(
   parameter int ADDR_WIDTH = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       head_valid,
   input  h263dep_pkg::cmd_info_type  head_info,
   input  logic [ADDR_WIDTH-1:0]      head_addr,
   output logic                       pop,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output h263dep_pkg::rsp_item_type  rsp_item
);

   logic                      busy_ff, busy_in;
   logic [1:0]                remaining_ff, remaining_in;
   logic [ADDR_WIDTH-1:0]     addr_ff, addr_in;
   h263dep_pkg::cmd_info_type info_ff, info_in;
   logic                      is_write, is_last, xfer, done, load;

   function automatic logic [15:0] ptr_to_16(input logic [ADDR_WIDTH-1:0] ptr);
      logic [ADDR_WIDTH+15:0] wide;
      wide = {16'd0, ptr};
      return wide[15:0];
   endfunction

   assign is_write  = (remaining_ff != h263dep_pkg::WRITES_NONE);
   assign is_last   = is_write ? (remaining_ff == h263dep_pkg::WRITES_ONE &&
                                  !info_ff.status_valid) : 1'b1;
   assign rsp_valid = busy_ff;
   assign xfer      = busy_ff && rsp_ready;
   assign done      = xfer && is_last;
   assign load      = (!busy_ff || done) && head_valid;
   assign pop       = load;

   always_comb begin
      rsp_item.write_valid  = is_write;
      rsp_item.write_addr   = is_write ? ptr_to_16(addr_ff) : 16'd0;
      rsp_item.write_byte   = is_write ? info_ff.write_byte : 8'd0;
      rsp_item.status_valid = !is_write;
      rsp_item.status       = is_write ? h263dep_pkg::ST_OK : info_ff.status;
      rsp_item.new_position = is_write ? 16'd0 : info_ff.new_position;
      rsp_item.last_result  = is_last;
   end

   always_comb begin
      busy_in      = busy_ff;
      remaining_in = remaining_ff;
      addr_in      = addr_ff;
      info_in      = info_ff;
      if (load) begin
         busy_in      = 1'b1;
         remaining_in = head_info.write_count;
         addr_in      = head_addr;
         info_in      = head_info;
      end else if (done) begin
         busy_in = 1'b0;
      end else if (xfer) begin
         // A write with more results to follow steps to the next address.
         remaining_in = remaining_ff - 2'd1;
         addr_in      = addr_ff + ADDR_WIDTH'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         remaining_ff <= h263dep_pkg::WRITES_NONE;
      end else begin
         busy_ff      <= busy_in;
         remaining_ff <= remaining_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff <= addr_in;
      info_ff <= info_in;
   end

endmodule

[rtl/h263_rtp_depacketizer_rfc4629.sv]
// H.263 RTP depacketizer top level (RFC 4629 payload format). Payload bytes or
// lost-packet notices enter on the req stream, one per cycle, and are parsed in
// the cycle they are accepted; each item gives zero to three results (bitstream
// writes with their addresses and a closing status), which wait as one command in
// a four-entry queue and leave the rsp stream one result per clock cycle while
// rsp_tready is high. The first result of an item is registered in the queue and
// then in the result stage before it is offered on the rsp stream. The input keeps
// its rate of one item per cycle as long as items give at most one result on
// average; the single result port sets the rate otherwise, and req_tready falls
// while the queue is full. The buffer_size register is written through the csr
// port, which is always ready and is meant to be written while the block is idle.
module h263_rtp_depacketizer_rfc4629 #(
   parameter int ADDR_WIDTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // data_byte [7:0], packet_length [23:8], picture_start [24], zero fill [31:25]
   input  logic [h263dep_pkg::REQ_TDATA_WIDTH-1:0] req_tdata,
   // last_byte
   input  logic        req_tlast,
   // op [0], first_byte [1]
   input  logic [1:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // write_addr [15:0], write_byte [23:16], status [25:24], new_position [41:26],
   // zero fill [47:42]
   output logic [h263dep_pkg::RSP_TDATA_WIDTH-1:0] rsp_tdata,
   // last_result
   output logic        rsp_tlast,
   // write_valid [0], status_valid [1]
   output logic [1:0]  rsp_tuser,
   input  logic        csr_valid,
   output logic        csr_ready,
   // buffer_size
   input  logic [15:0] csr_data
);

   localparam int INFO_W  = $bits(h263dep_pkg::cmd_info_type);
   localparam int ENTRY_W = INFO_W + ADDR_WIDTH;

   h263dep_pkg::req_item_type item;
   h263dep_pkg::cmd_info_type cmd_info, head_info;
   h263dep_pkg::rsp_item_type rsp_item;
   logic [ADDR_WIDTH-1:0]     cmd_addr, head_addr;
   logic [ENTRY_W-1:0]        head_data;
   logic                      item_accept, cmd_push, queue_full, head_valid, pop;

   assign csr_ready   = 1'b1;
   assign req_tready  = !queue_full;
   assign item_accept = req_tvalid && req_tready;

   assign item.op            = req_tuser[0];
   assign item.first_byte    = req_tuser[1];
   assign item.data_byte     = req_tdata[7:0];
   assign item.packet_length = req_tdata[23:8];
   assign item.picture_start = req_tdata[24];
   assign item.last_byte     = req_tlast;

   assign head_addr = head_data[ADDR_WIDTH-1:0];
   assign head_info = h263dep_pkg::cmd_info_type'(head_data[ENTRY_W-1:ADDR_WIDTH]);

   h263dep_front #(
      .ADDR_WIDTH(ADDR_WIDTH)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .item_accept (item_accept),
      .item        (item),
      .csr_write   (csr_valid && csr_ready),
      .csr_data    (csr_data),
      .cmd_push    (cmd_push),
      .cmd_info    (cmd_info),
      .cmd_addr    (cmd_addr)
   );

   h263dep_queue #(
      .WIDTH(ENTRY_W)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (cmd_push),
      .push_data  ({cmd_info, cmd_addr}),
      .pop        (pop),
      .full       (queue_full),
      .head_valid (head_valid),
      .head_data  (head_data)
   );

   h263dep_back #(
      .ADDR_WIDTH(ADDR_WIDTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_info  (head_info),
      .head_addr  (head_addr),
      .pop        (pop),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_item   (rsp_item)
   );

   assign rsp_tdata = {{h263dep_pkg::RSP_PAD_WIDTH{1'b0}}, rsp_item.new_position,
                       rsp_item.status, rsp_item.write_byte, rsp_item.write_addr};
   assign rsp_tlast = rsp_item.last_result;
   assign rsp_tuser = {rsp_item.status_valid, rsp_item.write_valid};

endmodule

[rtl/h263dep_checker.sv]
// Port-level checker for the depacketizer result stream, bound to the top level.
`include "h263_rtp_depacketizer_rfc4629_assert.svh"

module h263dep_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [h263dep_pkg::RSP_TDATA_WIDTH-1:0] rsp_tdata,
   input logic        rsp_tlast,
   input logic [1:0]  rsp_tuser
);

   // A stalled result keeps its contents until it is taken.
   `H263DEP_ASSERT(a_rsp_hold, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast) && $stable(rsp_tuser), "result changed while stalled")

   // Every result is either a write or a status, never both and never neither.
   `H263DEP_ASSERT(a_rsp_kind, rsp_tvalid |-> (rsp_tuser[0] ^ rsp_tuser[1]), "result kind is not unique")

   // A status always closes the results of its input item.
   `H263DEP_ASSERT(a_status_last, rsp_tvalid && rsp_tuser[1] |-> rsp_tlast, "status result is not the last one")

   // Fields of the other result kind and the fill bits read as zero.
   `H263DEP_ASSERT(a_rsp_zero, rsp_tvalid |-> rsp_tdata[47:42] == 6'd0 && (rsp_tuser[0] ? rsp_tdata[41:24] == 18'd0 : rsp_tdata[23:0] == 24'd0), "unused result fields are not zero")

endmodule

bind h263_rtp_depacketizer_rfc4629 h263dep_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast),
   .rsp_tuser  (rsp_tuser)
);

[test/h263_rtp_depacketizer_rfc4629_checker.sv]
// Checker for the H.263 RTP depacketizer: predicts writes and statuses and compares them.
module h263_rtp_depacketizer_rfc4629_checker
   import h263dep_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   input  logic                       req_tready,
   input  logic [REQ_TDATA_WIDTH-1:0] req_tdata,
   input  logic                       req_tlast,
   input  logic [1:0]                 req_tuser,
   input  logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   input  logic [RSP_TDATA_WIDTH-1:0] rsp_tdata,
   input  logic                       rsp_tlast,
   input  logic [1:0]                 rsp_tuser,
   input  logic                       csr_valid,
   input  logic                       csr_ready,
   input  logic [15:0]                csr_data,
   output int                         fail_count,
   output int                         pending
);

   // Model copy of the depacketizer state.
   logic [15:0] buf_room;
   logic [15:0] wr_offset;
   logic [15:0] sync_offset;
   logic [15:0] pos_in_packet;
   logic [15:0] dest_ptr;
   logic [5:0]  extra_hdr_len;
   logic        lost_flag;
   logic        p_bit;
   logic        v_bit;
   logic        hunting_sync;
   logic        zero_seen;
   logic        in_payload;
   status_type  outcome;

   rsp_item_type predicted_bitstream[$];
   rsp_item_type step_bitstream[$];
   int mismatches = 0;

   function automatic void emit_write(input logic [7:0] value);
      rsp_item_type r;
      r = '0;
      r.write_valid = 1'b1;
      r.write_addr = dest_ptr;
      r.write_byte = value;
      step_bitstream.push_back(r);
      dest_ptr = dest_ptr + 16'd1;
   endfunction

   function automatic void emit_status(input status_type st);
      rsp_item_type r;
      r = '0;
      r.status_valid = 1'b1;
      r.status = st;
      r.new_position = wr_offset;
      step_bitstream.push_back(r);
   endfunction

   function automatic void depacketize_item(input req_item_type it);
      int unsigned idx;
      int unsigned hdr_len;
      int unsigned need;
      status_type st;
      step_bitstream.delete();
      if (it.op == OP_LOST) begin
         lost_flag = 1'b1;
         emit_status(ST_OK);
      end else begin
         if (it.first_byte) begin
            // A new first byte drops whatever packet was still open.
            in_payload = 1'b1;
            pos_in_packet = '0;
            if (it.picture_start) wr_offset = '0;
            outcome = ST_OK;
            hunting_sync = 1'b0;
            zero_seen = 1'b0;
            p_bit = 1'b0;
            v_bit = 1'b0;
            extra_hdr_len = '0;
            dest_ptr = wr_offset;
         end
         if (in_payload) begin
            idx = 32'(pos_in_packet);
            if (it.last_byte && outcome == ST_OK && idx + 1 < 32'(it.packet_length))
               outcome = ST_INVALID;
            if (outcome == ST_OK) begin
               hdr_len = 2 + 32'(v_bit) + 32'(extra_hdr_len);
               if (idx == 0) begin
                  if (it.packet_length < MIN_PACKET_LENGTH) begin
                     outcome = ST_INVALID;
                  end else begin
                     if (wr_offset == 0) sync_offset = '0;
                     p_bit = it.data_byte[P_FLAG_BIT];
                     v_bit = it.data_byte[V_FLAG_BIT];
                     extra_hdr_len = {it.data_byte[PLEN_HIGH_BIT], 5'b0};
                  end
               end else if (idx == 1) begin
                  extra_hdr_len[4:0] = it.data_byte[7:PLEN_LOW_LSB];
                  hdr_len = 2 + 32'(v_bit) + 32'(extra_hdr_len);
                  if (32'(it.packet_length) <= hdr_len) begin
                     outcome = ST_INVALID;
                  end else begin
                     need = 32'(wr_offset) + (32'(it.packet_length) - hdr_len) + 2;
                     // A new picture without P also gets its picture header copied.
                     if (!p_bit && wr_offset == 0) need = need + 32'(extra_hdr_len);
                     if (32'(buf_room) < need) begin
                        outcome = ST_SMALL;
                     end else begin
                        zero_seen = 1'b0;
                        hunting_sync = 1'b0;
                        dest_ptr = wr_offset;
                        if (!p_bit) begin
                           if (wr_offset == 0) begin
                              lost_flag = 1'b1;
                              if (extra_hdr_len != 0) begin
                                 emit_write(8'h00);
                                 emit_write(8'h00);
                              end
                           end else if (lost_flag) begin
                              dest_ptr = sync_offset;
                           end
                           hunting_sync = lost_flag;
                        end else begin
                           sync_offset = dest_ptr;
                           emit_write(8'h00);
                           emit_write(8'h00);
                        end
                     end
                  end
               end else if (idx < hdr_len) begin
                  if (!p_bit && wr_offset == 0 && idx >= 2 + 32'(v_bit))
                     emit_write(it.data_byte);
               end else if (idx < 32'(it.packet_length)) begin
                  if (hunting_sync) begin
                     if (zero_seen && it.data_byte == 8'h00) begin
                        hunting_sync = 1'b0;
                        zero_seen = 1'b0;
                        sync_offset = dest_ptr;
                        emit_write(8'h00);
                        emit_write(8'h00);
                     end else begin
                        zero_seen = (it.data_byte == 8'h00);
                     end
                  end else begin
                     emit_write(it.data_byte);
                  end
               end
            end
            if (pos_in_packet != BYTE_INDEX_MAX) pos_in_packet = pos_in_packet + 16'd1;
            if (it.last_byte) begin
               st = outcome;
               if (outcome == ST_OK) begin
                  if (hunting_sync) begin
                     st = ST_IGNORED;
                  end else begin
                     wr_offset = dest_ptr;
                     lost_flag = 1'b0;
                  end
               end else begin
                  lost_flag = 1'b1;
               end
               emit_status(st);
               in_payload = 1'b0;
            end
         end
      end
      if (step_bitstream.size() > 0)
         step_bitstream[step_bitstream.size() - 1].last_result = 1'b1;
      foreach (step_bitstream[k]) predicted_bitstream.push_back(step_bitstream[k]);
   endfunction

   function automatic void check_field(input string name, input int unsigned want,
                                       input int unsigned got);
      if (want != got) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin
      req_item_type it;
      rsp_item_type got;
      rsp_item_type want;
      if (reset) begin
         buf_room = BUFFER_SIZE_RESET;
         wr_offset = '0;
         sync_offset = '0;
         pos_in_packet = '0;
         dest_ptr = '0;
         extra_hdr_len = '0;
         lost_flag = 1'b0;
         p_bit = 1'b0;
         v_bit = 1'b0;
         hunting_sync = 1'b0;
         zero_seen = 1'b0;
         in_payload = 1'b0;
         outcome = ST_OK;
         predicted_bitstream.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.write_valid = rsp_tuser[0];
            got.status_valid = rsp_tuser[1];
            got.write_addr = rsp_tdata[15:0];
            got.write_byte = rsp_tdata[23:16];
            got.status = status_type'(rsp_tdata[25:24]);
            got.new_position = rsp_tdata[41:26];
            got.last_result = rsp_tlast;
            if (predicted_bitstream.size() == 0) begin
               $error("result transfer with nothing predicted: addr 0x%0h status_valid %0b",
                      got.write_addr, got.status_valid);
               mismatches++;
            end else begin
               want = predicted_bitstream.pop_front();
               check_field("write_valid", 32'(want.write_valid), 32'(got.write_valid));
               check_field("write_addr", 32'(want.write_addr), 32'(got.write_addr));
               check_field("write_byte", 32'(want.write_byte), 32'(got.write_byte));
               check_field("status_valid", 32'(want.status_valid), 32'(got.status_valid));
               check_field("status", 32'(want.status), 32'(got.status));
               check_field("new_position", 32'(want.new_position), 32'(got.new_position));
               check_field("last_result", 32'(want.last_result), 32'(got.last_result));
            end
         end
         if (csr_valid && csr_ready) buf_room = csr_data;
         if (req_tvalid && req_tready) begin
            it.op = req_tuser[0];
            it.first_byte = req_tuser[1];
            it.data_byte = req_tdata[7:0];
            it.packet_length = req_tdata[23:8];
            it.picture_start = req_tdata[24];
            it.last_byte = req_tlast;
            depacketize_item(it);
         end
      end
      pending <= predicted_bitstream.size();
      fail_count <= mismatches;
   end

endmodule

[test/h263_rtp_depacketizer_rfc4629_tb.sv]
// Testbench top for the H.263 RTP depacketizer: stimulus, configuration and verdict.
module h263_rtp_depacketizer_rfc4629_tb;
   import h263dep_pkg::*;

   typedef logic [7:0] byte_queue_type[$];

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid;
   logic req_tready;
   logic [REQ_TDATA_WIDTH-1:0] req_tdata;
   logic req_tlast;
   logic [1:0] req_tuser;
   logic rsp_tvalid;
   logic rsp_tready;
   logic [RSP_TDATA_WIDTH-1:0] rsp_tdata;
   logic rsp_tlast;
   logic [1:0] rsp_tuser;
   logic csr_valid;
   logic csr_ready;
   logic [15:0] csr_data;

   int fail_count;
   int pending;
   int unsigned phase_items;
   logic hold_rsp = 1'b0;
   logic steady = 1'b0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   h263_rtp_depacketizer_rfc4629 uut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .req_tlast(req_tlast), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tlast(rsp_tlast), .rsp_tuser(rsp_tuser),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   h263_rtp_depacketizer_rfc4629_checker checker_inst (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .req_tlast(req_tlast), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tlast(rsp_tlast), .rsp_tuser(rsp_tuser),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data),
      .fail_count(fail_count), .pending(pending)
   );

   // Result side: random stalls, or one long hold-off that lets the block fill up.
   initial begin
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_rsp) begin
            rsp_tready <= 1'b0;
            repeat (80) @(posedge clock);
            hold_rsp = 1'b0;
         end else begin
            rsp_tready <= steady || $urandom_range(99) >= 34;
         end
      end
   end

   initial begin
      #2000000;
      $display("Some tests failed");
      $finish;
   end

   task automatic send_item(input req_item_type it);
      while (!steady && $urandom_range(99) < 34) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {{REQ_PAD_WIDTH{1'b0}}, it.picture_start, it.packet_length, it.data_byte};
      req_tlast <= it.last_byte;
      req_tuser <= {it.first_byte, it.op};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic send_lost();
      req_item_type it;
      it.op = OP_LOST;
      it.data_byte = 8'($urandom_range(255));
      it.first_byte = 1'($urandom_range(1));
      it.last_byte = 1'($urandom_range(1));
      it.packet_length = 16'($urandom_range(65535));
      it.picture_start = 1'($urandom_range(1));
      send_item(it);
      phase_items++;
   endtask

   // A byte outside any packet; the block drops it without a result.
   task automatic send_stray();
      req_item_type it;
      it.op = OP_BYTE;
      it.data_byte = 8'($urandom_range(255));
      it.first_byte = 1'b0;
      it.last_byte = 1'($urandom_range(1));
      it.packet_length = 16'($urandom_range(65535));
      it.picture_start = 1'($urandom_range(1));
      send_item(it);
   endtask

   task automatic send_payload(input byte_queue_type payload, input logic [15:0] declared,
                               input logic pic, input logic close, input int unsigned noise);
      req_item_type it;
      foreach (payload[k]) begin
         if (k > 0 && $urandom_range(99) < noise) send_lost();
         it.op = OP_BYTE;
         it.data_byte = payload[k];
         it.first_byte = (k == 0);
         it.last_byte = close && (k == payload.size() - 1);
         it.packet_length = declared;
         it.picture_start = pic;
         send_item(it);
         phase_items++;
      end
   endtask

   function automatic logic [7:0] random_data();
      return ($urandom_range(99) < 35) ? 8'h00 : 8'($urandom_range(255));
   endfunction

   task automatic random_traffic();
      byte_queue_type pl;
      int unsigned kind;
      int unsigned extra;
      int unsigned cut;
      logic [7:0] h0;
      logic [7:0] h1;
      logic [15:0] declared;
      logic v;
      logic pic;
      kind = $urandom_range(99);
      if (kind < 6) begin
         send_lost();
      end else if (kind < 10) begin
         send_stray();
      end else begin
         v = 1'($urandom_range(1));
         extra = ($urandom_range(2) == 0) ? $urandom_range(1, 3) : 0;
         h0 = {5'($urandom_range(31)), 1'($urandom_range(1)), v, 1'b0};
         h1 = {5'(extra), 3'($urandom_range(7))};
         pl = '{h0, h1};
         if (v) pl.push_back(8'($urandom_range(255)));
         repeat (extra) pl.push_back(random_data());
         repeat ($urandom_range(1, 6)) pl.push_back(random_data());
         declared = 16'(pl.size());
         pic = ($urandom_range(3) == 0);
         cut = $urandom_range(1, pl.size() - 1);
         if (kind < 70) begin
            send_payload(pl, declared, pic, 1'b1, 3);
         end else if (kind < 78) begin
            // Payload ends before its declared length.
            if ($urandom_range(1) == 1) begin
               declared = 16'($urandom_range(256, 65535));
               send_payload(pl, declared, pic, 1'b1, 0);
            end else begin
               send_payload(pl[0:cut-1], declared, pic, 1'b1, 0);
            end
         end else if (kind < 86) begin
            declared = 16'($urandom_range(0, 2 + 32'(v) + extra));
            send_payload(pl, declared, pic, 1'b1, 0);
         end else if (kind < 93) begin
            repeat ($urandom_range(1, 2)) pl.push_back(8'($urandom_range(255)));
            send_payload(pl, declared, pic, 1'b1, 0);
         end else begin
            // An unfinished packet is cut off by the next first byte.
            send_payload(pl[0:cut-1], declared, pic, 1'b0, 0);
            send_payload(pl, declared, pic, 1'b1, 0);
         end
      end
   endtask

   // Waits until every predicted result has left the block and the pipeline is empty.
   task automatic settle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_buffer_size(input logic [15:0] value);
      csr_valid <= 1'b1;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   initial begin
      logic [15:0] room_setting [4];
      req_tvalid <= 1'b0;
      req_tdata <= '0;
      req_tlast <= 1'b0;
      req_tuser <= '0;
      csr_valid <= 1'b0;
      csr_data <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      write_buffer_size(16'hFFFF);

      send_lost();
      send_stray();
      // P set on a new picture: two sync zeros come first.
      send_payload('{8'h04, 8'h00, 8'hFF}, 16'd3, 1'b1, 1'b1, 0);
      send_payload('{8'h00}, 16'd1, 1'b0, 1'b1, 0);
      // VRC byte and one extra header byte; a zero pair ends the sync search.
      send_payload('{8'h02, 8'h08, 8'h5A, 8'hC3, 8'h00, 8'h00}, 16'd6, 1'b1, 1'b1, 0);
      send_payload('{8'h04, 8'h00, 8'h12}, 16'd6, 1'b0, 1'b1, 0);
      // After that loss, a payload with no zero pair is ignored.
      send_payload('{8'hF8, 8'h07, 8'h00, 8'h33}, 16'd4, 1'b0, 1'b1, 0);
      send_payload('{8'h04, 8'h00, 8'h11, 8'h22}, 16'd3, 1'b0, 1'b1, 0);
      // Largest PLEN and the largest declared length, cut short.
      send_payload('{8'h01, 8'hF8, 8'hAA}, 16'hFFFF, 1'b1, 1'b1, 0);
      settle();

      room_setting = '{16'hFFFF, 16'h0000, 16'($urandom_range(10, 30)),
                       16'($urandom_range(65535))};
      for (int p = 0; p < 4; p++) begin
         write_buffer_size(room_setting[p]);
         steady = (p == 2);
         if (p == 0) hold_rsp = 1'b1;
         phase_items = 0;
         while (phase_items < 18) random_traffic();
         settle();
      end

      if (fail_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

[sim.f]
+incdir+rtl
rtl/h263dep_pkg.sv
rtl/h263dep_queue.sv
rtl/h263dep_front.sv
rtl/h263dep_back.sv
rtl/h263_rtp_depacketizer_rfc4629.sv
rtl/h263dep_checker.sv
test/h263_rtp_depacketizer_rfc4629_checker.sv
test/h263_rtp_depacketizer_rfc4629_tb.sv
